/* src/tga_rle_pixel_decoder_defines.svh */
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_defines.svh
// Assertion macros shared by the TGA decoder modules.
// ---------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle check, quiet while rst is high.
`define TGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Next-cycle check: ante in one cycle implies cons in the next.
`define TGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TGA_ASSERT(lbl, prop, msg)
`define TGA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* src/tga_pkg.sv */
// ---------------------------------------------------------------------------
// tga_pkg
// Beat types, phase codes and header constants for the TGA pixel decoder.
// ---------------------------------------------------------------------------
package tga_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
    logic [1:0] error_code;
  } out_beat_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PACKET,
    PH_PIXEL,
    PH_HALT
  } phase_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_HEADER   = 2'd1;
  localparam logic [1:0] ERR_SIZE     = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // Header byte positions
  localparam logic [4:0] IDX_TYPE   = 5'd2;
  localparam logic [4:0] SIG_LEN    = 5'd12;
  localparam logic [4:0] IDX_W_LO   = 5'd12;
  localparam logic [4:0] IDX_W_HI   = 5'd13;
  localparam logic [4:0] IDX_H_LO   = 5'd14;
  localparam logic [4:0] IDX_H_HI   = 5'd15;
  localparam logic [4:0] IDX_DEPTH  = 5'd16;

  localparam logic [7:0] TYPE_RAW   = 8'd2;
  localparam logic [7:0] TYPE_RLE   = 8'd10;
  localparam logic [7:0] DEPTH_RGB  = 8'd24;
  localparam logic [7:0] DEPTH_RGBA = 8'd32;

endpackage

/* src/tga_rle_pixel_decoder.sv */
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Streaming TGA decoder (uncompressed and run-length), one file byte a beat.
// ---------------------------------------------------------------------------
// Usage:
//   in channel  : one file byte per beat; start_of_file marks the first byte
//                 of a file and restarts the decoder at any point.
//   out channel : one beat per finished pixel (with repeat_count for runs)
//                 or per error; last_pixel marks the end of an image. After
//                 an error or the last pixel, bytes are dropped until the
//                 next start_of_file.
//   Throughput  : one byte per clock. Every byte is decoded in the cycle it
//                 is accepted; header, packet and pixel logic is a single
//                 combinational pass into the state and result registers.
//   Output      : each result is registered, in out or in the skid entry.
//   Stall       : the output register plus a one-entry skid buffer let one
//                 more result land while out_ready is low; in_ready drops
//                 only while the skid entry is occupied.
//   Reset       : rst (synchronous) empties both output stages and puts the
//                 decoder idle; bytes before the first start are dropped.
// ---------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_defines.svh"

module tga_rle_pixel_decoder
  import tga_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic      accept;
  logic      res_valid;
  out_beat_t res;

  // skid entry, used only while out is stalled
  logic      skid_valid;
  out_beat_t skid_data;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  tga_dec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .beat      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;           // skid moves to out
        end else if (!res_valid) begin
          out_valid <= 1'b0;
        end
      end else if (!out_valid) begin
        out_valid <= res_valid;
      end else if (res_valid) begin
        skid_valid <= 1'b1;             // out stalled: park new result
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (res_valid) begin
        out_data <= res;
      end
    end else if (!out_valid) begin
      if (res_valid) begin
        out_data <= res;
      end
    end else if (res_valid) begin
      skid_data <= res;
    end
  end

  `TGA_ASSERT(a_skid_needs_out, !skid_valid || out_valid, "skid holds data while out is empty")
  `TGA_ASSERT_NEXT(a_stall_parks, res_valid && out_valid && !out_ready, skid_valid, "stalled result not parked in skid")
  `TGA_ASSERT_NEXT(a_skid_drains, skid_valid && out_ready, !skid_valid && out_valid, "skid entry not moved to out")

endmodule

/* src/tga_dec_core.sv */
// ---------------------------------------------------------------------------
// tga_dec_core
// Per-byte decode: header parse, packet headers, pixel assembly, at most one result.
// ---------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_defines.svh"

module tga_dec_core
  import tga_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  in_beat_t  beat,
  output logic      res_valid,
  output out_beat_t res
);

  phase_t      phase, phase_next;
  logic [4:0]  header_index, header_index_next;
  logic        is_compressed, is_compressed_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic        four_bytes, four_bytes_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [7:0]  packet_left, packet_left_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [7:0]  color_bytes [3];
  logic [7:0]  color_bytes_next [3];

  // State as seen after a start flag restart, else the stored state
  phase_t      cur_phase;
  logic [4:0]  cur_index;
  logic        cur_comp;
  logic [15:0] cur_width, cur_height;
  logic        cur_four;
  logic [31:0] cur_left;
  logic        cur_run;
  logic [7:0]  cur_pkt;
  logic [1:0]  cur_bip;
  logic [7:0]  cur_color [3];

  logic [31:0] area;
  logic [7:0]  pkt_count;
  logic [1:0]  last_idx;
  logic [7:0]  rep;
  logic [7:0]  b;

  assign b         = beat.data_byte;
  assign area      = {16'd0, image_width} * {16'd0, image_height};
  // raw h+1 and run h-127 both reduce to low seven bits plus one
  assign pkt_count = {1'b0, b[6:0]} + 8'd1;

  always_comb begin
    if (beat.start_of_file) begin
      cur_phase  = PH_HEADER;
      cur_index  = '0;
      cur_comp   = 1'b0;
      cur_width  = '0;
      cur_height = '0;
      cur_four   = 1'b0;
      cur_left   = '0;
      cur_run    = 1'b0;
      cur_pkt    = '0;
      cur_bip    = '0;
      for (int i = 0; i < 3; i++) cur_color[i] = '0;
    end else begin
      cur_phase  = phase;
      cur_index  = header_index;
      cur_comp   = is_compressed;
      cur_width  = image_width;
      cur_height = image_height;
      cur_four   = four_bytes;
      cur_left   = pixels_left;
      cur_run    = packet_is_run;
      cur_pkt    = packet_left;
      cur_bip    = byte_in_pixel;
      for (int i = 0; i < 3; i++) cur_color[i] = color_bytes[i];
    end
  end

  assign last_idx = cur_four ? 2'd3 : 2'd2;
  assign rep      = (cur_comp && cur_run) ? cur_pkt : 8'd1;

  always_comb begin
    phase_next         = phase;
    header_index_next  = header_index;
    is_compressed_next = is_compressed;
    image_width_next   = image_width;
    image_height_next  = image_height;
    four_bytes_next    = four_bytes;
    pixels_left_next   = pixels_left;
    packet_is_run_next = packet_is_run;
    packet_left_next   = packet_left;
    byte_in_pixel_next = byte_in_pixel;
    for (int i = 0; i < 3; i++) color_bytes_next[i] = color_bytes[i];
    res_valid = 1'b0;
    res       = '0;

    if (accept) begin
      phase_next         = cur_phase;
      header_index_next  = cur_index;
      is_compressed_next = cur_comp;
      image_width_next   = cur_width;
      image_height_next  = cur_height;
      four_bytes_next    = cur_four;
      pixels_left_next   = cur_left;
      packet_is_run_next = cur_run;
      packet_left_next   = cur_pkt;
      byte_in_pixel_next = cur_bip;
      for (int i = 0; i < 3; i++) color_bytes_next[i] = cur_color[i];

      case (cur_phase)
        PH_HEADER: begin
          header_index_next = cur_index + 5'd1;
          if (cur_index < SIG_LEN) begin
            if (cur_index == IDX_TYPE) begin
              if (b == TYPE_RAW) begin
                is_compressed_next = 1'b0;
              end else if (b == TYPE_RLE) begin
                is_compressed_next = 1'b1;
              end else begin
                res_valid        = 1'b1;
                res.error_code   = ERR_HEADER;
                phase_next       = PH_HALT;
              end
            end else if (b != 8'd0) begin
              res_valid      = 1'b1;
              res.error_code = ERR_HEADER;
              phase_next     = PH_HALT;
            end
          end else if (cur_index == IDX_W_LO) begin
            image_width_next = {cur_width[15:8], b};
          end else if (cur_index == IDX_W_HI) begin
            image_width_next = {b, cur_width[7:0]};
          end else if (cur_index == IDX_H_LO) begin
            image_height_next = {cur_height[15:8], b};
          end else if (cur_index == IDX_H_HI) begin
            image_height_next = {b, cur_height[7:0]};
          end else if (cur_index == IDX_DEPTH) begin
            if (cur_width == 16'd0 || cur_height == 16'd0 ||
                (b != DEPTH_RGB && b != DEPTH_RGBA)) begin
              res_valid      = 1'b1;
              res.error_code = ERR_SIZE;
              phase_next     = PH_HALT;
            end
            four_bytes_next = (b == DEPTH_RGBA);
          end else begin
            // descriptor byte: ignored, pixel data follows
            header_index_next  = cur_index;
            pixels_left_next   = area;
            byte_in_pixel_next = '0;
            packet_left_next   = '0;
            packet_is_run_next = 1'b0;
            phase_next         = cur_comp ? PH_PACKET : PH_PIXEL;
          end
        end

        PH_PACKET: begin
          packet_is_run_next = b[7];
          if ({24'd0, pkt_count} > cur_left) begin
            res_valid      = 1'b1;
            res.error_code = ERR_OVERFLOW;
            phase_next     = PH_HALT;
          end else begin
            packet_left_next   = pkt_count;
            byte_in_pixel_next = '0;
            phase_next         = PH_PIXEL;
          end
        end

        PH_PIXEL: begin
          if (cur_bip < last_idx) begin
            color_bytes_next[cur_bip] = b;
            byte_in_pixel_next        = cur_bip + 2'd1;
          end else begin
            pixels_left_next   = cur_left - {24'd0, rep};
            byte_in_pixel_next = '0;
            if (cur_comp) begin
              packet_left_next = cur_run ? 8'd0 : cur_pkt - 8'd1;
            end
            res_valid        = 1'b1;
            res.red          = cur_four ? cur_color[2] : b;
            res.green        = cur_color[1];
            res.blue         = cur_color[0];
            res.alpha        = cur_four ? b : 8'd0;
            res.has_alpha    = cur_four;
            res.repeat_count = rep;
            res.last_pixel   = (pixels_left_next == 32'd0);
            res.error_code   = ERR_NONE;
            if (pixels_left_next == 32'd0) begin
              phase_next = PH_HALT;
            end else if (cur_comp && packet_left_next == 8'd0) begin
              phase_next = PH_PACKET;
            end
          end
        end

        default: begin
          // idle or halted: byte dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_index  <= '0;
      is_compressed <= 1'b0;
      image_width   <= '0;
      image_height  <= '0;
      four_bytes    <= 1'b0;
      pixels_left   <= '0;
      packet_is_run <= 1'b0;
      packet_left   <= '0;
      byte_in_pixel <= '0;
      for (int i = 0; i < 3; i++) color_bytes[i] <= '0;
    end else begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      is_compressed <= is_compressed_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      four_bytes    <= four_bytes_next;
      pixels_left   <= pixels_left_next;
      packet_is_run <= packet_is_run_next;
      packet_left   <= packet_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      for (int i = 0; i < 3; i++) color_bytes[i] <= color_bytes_next[i];
    end
  end

  `TGA_ASSERT_NEXT(a_err_halts, res_valid && res.error_code != ERR_NONE, phase == PH_HALT, "error result did not halt decoder")
  `TGA_ASSERT_NEXT(a_last_halts, res_valid && res.last_pixel, phase == PH_HALT, "last pixel did not halt decoder")
  `TGA_ASSERT(a_rep_nonzero, !(res_valid && res.error_code == ERR_NONE) || res.repeat_count != 8'd0, "pixel result with zero repeat count")
  `TGA_ASSERT_NEXT(a_hold_idle, !accept, $stable(phase) && $stable(pixels_left), "state moved without a byte")

endmodule

/* tb/tga_rle_pixel_decoder_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_checker
// Watches both channels, predicts each pixel or error beat from the accepted
// file bytes and compares it field by field with what the decoder puts out.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder_checker
  import tga_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam logic [4:0] IDX_DESC = 5'd17;
  localparam logic [7:0] RUN_BIAS = 8'd127;

  // decoder state as predicted
  phase_t      phase;
  logic [4:0]  hdr_idx;
  logic        rle_mode;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic        four;
  logic [31:0] pixels_due;
  logic        in_run;
  logic [7:0]  packet_due;
  logic [1:0]  byte_idx;
  logic [7:0]  color [3];

  out_beat_t   expected_px[$];
  int          errors = 0;

  task automatic clear_decoder();
    phase      = PH_IDLE;
    hdr_idx    = '0;
    rle_mode   = 1'b0;
    img_w      = '0;
    img_h      = '0;
    four       = 1'b0;
    pixels_due = '0;
    in_run     = 1'b0;
    packet_due = '0;
    byte_idx   = '0;
    color[0]   = '0;
    color[1]   = '0;
    color[2]   = '0;
  endtask

  // One file byte in, at most one pixel (or error) beat out.
  task automatic decode_byte(input in_beat_t beat, output logic emit, output out_beat_t px);
    logic [7:0]  b;
    logic [31:0] n;
    logic [1:0]  err;
    b    = beat.data_byte;
    emit = 1'b0;
    px   = '0;
    err  = ERR_NONE;
    if (beat.start_of_file) begin
      clear_decoder();
      phase = PH_HEADER;
    end
    case (phase)
      PH_HEADER: begin
        if (hdr_idx < SIG_LEN) begin
          if (hdr_idx == IDX_TYPE) begin
            if (b == TYPE_RAW) rle_mode = 1'b0;
            else if (b == TYPE_RLE) rle_mode = 1'b1;
            else err = ERR_HEADER;
          end else if (b != 8'd0) begin
            err = ERR_HEADER;
          end
        end else if (hdr_idx == IDX_W_LO) begin
          img_w[7:0] = b;
        end else if (hdr_idx == IDX_W_HI) begin
          img_w[15:8] = b;
        end else if (hdr_idx == IDX_H_LO) begin
          img_h[7:0] = b;
        end else if (hdr_idx == IDX_H_HI) begin
          img_h[15:8] = b;
        end else if (hdr_idx == IDX_DEPTH) begin
          if (img_w == 16'd0 || img_h == 16'd0 || (b != DEPTH_RGB && b != DEPTH_RGBA))
            err = ERR_SIZE;
          four = (b == DEPTH_RGBA);
        end else begin
          // descriptor byte: ignored, pixel data follows
          pixels_due = {16'd0, img_w} * {16'd0, img_h};
          byte_idx   = '0;
          packet_due = '0;
          in_run     = 1'b0;
          phase      = rle_mode ? PH_PACKET : PH_PIXEL;
        end
        if (hdr_idx != IDX_DESC) hdr_idx = hdr_idx + 5'd1;
      end
      PH_PACKET: begin
        if (b[7]) n = {24'd0, b} - {24'd0, RUN_BIAS};
        else n = {24'd0, b} + 32'd1;
        if (n > pixels_due) begin
          err = ERR_OVERFLOW;
        end else begin
          in_run     = b[7];
          packet_due = n[7:0];
          byte_idx   = '0;
          phase      = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        if (byte_idx < (four ? 2'd3 : 2'd2)) begin
          color[byte_idx] = b;
          byte_idx = byte_idx + 2'd1;
        end else begin
          px.red          = four ? color[2] : b;
          px.green        = color[1];
          px.blue         = color[0];
          px.alpha        = four ? b : 8'd0;
          px.has_alpha    = four;
          px.repeat_count = (rle_mode && in_run) ? packet_due : 8'd1;
          px.error_code   = ERR_NONE;
          pixels_due      = pixels_due - {24'd0, px.repeat_count};
          if (rle_mode) packet_due = in_run ? 8'd0 : packet_due - 8'd1;
          byte_idx        = '0;
          px.last_pixel   = (pixels_due == 32'd0);
          if (px.last_pixel) phase = PH_HALT;
          else if (rle_mode && packet_due == 8'd0) phase = PH_PACKET;
          emit = 1'b1;
        end
      end
      default: ;
    endcase
    if (err != ERR_NONE) begin
      px            = '0;
      px.error_code = err;
      emit          = 1'b1;
      phase         = PH_HALT;
    end
  endtask

  function automatic int field_bad(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  // Output side is checked before the input side: a beat accepted at this
  // edge cannot show up on out before the next one.
  always @(posedge clk) begin : watch
    out_beat_t want;
    out_beat_t px;
    logic      emit;
    if (rst) begin
      clear_decoder();
      expected_px.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_px.size() == 0) begin
          $display("%0t ns: unexpected pixel beat, expected none, actual %h", $time, out_data);
          errors++;
        end else begin
          want = expected_px.pop_front();
          errors += field_bad("red", 32'(want.red), 32'(out_data.red))
                  + field_bad("green", 32'(want.green), 32'(out_data.green))
                  + field_bad("blue", 32'(want.blue), 32'(out_data.blue))
                  + field_bad("alpha", 32'(want.alpha), 32'(out_data.alpha))
                  + field_bad("has_alpha", 32'(want.has_alpha), 32'(out_data.has_alpha))
                  + field_bad("repeat_count", 32'(want.repeat_count),
                              32'(out_data.repeat_count))
                  + field_bad("last_pixel", 32'(want.last_pixel), 32'(out_data.last_pixel))
                  + field_bad("error_code", 32'(want.error_code), 32'(out_data.error_code));
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data, emit, px);
        if (emit) expected_px.push_back(px);
      end
    end
    fail_count <= errors;
    pending    <= expected_px.size();
  end

endmodule

/* tb/tga_rle_pixel_decoder_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_tb
// Feeds TGA byte streams (good files, bad headers, overflowing packets,
// abandoned files and stray bytes) through the decoder with random gaps and
// back-pressure; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder_tb;
  import tga_pkg::*;

  localparam int ITEM_TARGET   = 1250;
  localparam int IDLE_PCT      = 21;
  localparam int SETTLE_CYCLES = 20;
  // ~1400 beats at most; even with random gaps and stalls the run stays far
  // below this.
  localparam int CYCLE_LIMIT   = 400000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  int        fail_count;
  int        pending;
  int        beats_sent  = 0;
  int        cycle_count = 0;
  bit        calm        = 1'b0;   // no gaps and no stalls while set
  logic [7:0] file_bytes[$];       // file under construction

  always #1 clk = ~clk;

  tga_rle_pixel_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tga_rle_pixel_decoder_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One byte beat. Random gaps go before the beat; valid is only lowered
  // in steps where it is not also raised.
  task automatic send_beat(input logic [7:0] value, input logic sof);
    in_beat_t beat;
    beat.data_byte     = value;
    beat.start_of_file = sof;
    if (!calm) begin
      while ($urandom_range(99, 0) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_beat(file_bytes[i], i == 0);
    file_bytes.delete();
  endtask

  // Bytes without a start flag; dropped by an idle or halted decoder.
  task automatic send_noise(input int count);
    repeat (count) send_beat(8'($urandom_range(255, 0)), 1'b0);
  endtask

  // Hold the sender until every predicted beat has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic build_header(input bit rle, input logic [15:0] w, input logic [15:0] h,
                              input logic [7:0] depth, input logic [7:0] desc);
    file_bytes.delete();
    for (int k = 0; k < SIG_LEN; k++) begin
      if (k == IDX_TYPE) file_bytes.push_back(rle ? TYPE_RLE : TYPE_RAW);
      else file_bytes.push_back(8'd0);
    end
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
    file_bytes.push_back(depth);
    file_bytes.push_back(desc);
  endtask

  task automatic add_pixel(input bit four);
    repeat (four ? 4 : 3) file_bytes.push_back(8'($urandom_range(255, 0)));
  endtask

  // Pixel data for a w x h image. In run-length mode, ovf_pct is the chance
  // that a packet asks for more pixels than are left (the decoder halts).
  task automatic build_body(input bit rle, input int w, input int h, input bit four,
                            input int ovf_pct);
    int unsigned remaining;
    int unsigned cap;
    int unsigned k;
    logic [7:0]  pkt;
    remaining = w * h;
    if (!rle) begin
      repeat (remaining) add_pixel(four);
    end else begin
      while (remaining != 0) begin
        cap = (remaining < 128) ? remaining : 128;
        if (remaining < 128 && $urandom_range(99, 0) < ovf_pct) begin
          k   = $urandom_range(128, remaining + 1);
          pkt = $urandom_range(1, 0) ? 8'(k + 127) : 8'(k - 1);
          file_bytes.push_back(pkt);
          add_pixel(four);
          remaining = 0;
        end else begin
          k = ($urandom_range(3, 0) == 0) ? cap : $urandom_range(cap, 1);
          if ($urandom_range(1, 0) != 0) begin
            pkt = 8'(k + 127);  // run: one pixel, k copies
            file_bytes.push_back(pkt);
            add_pixel(four);
          end else begin
            pkt = 8'(k - 1);    // raw: k pixels follow
            file_bytes.push_back(pkt);
            repeat (k) add_pixel(four);
          end
          remaining -= k;
        end
      end
    end
  endtask

  initial begin
    int         roll;
    int         w;
    int         h;
    int         cut;
    bit         rle;
    bit         four;
    bit         mid_drain_done;
    logic [7:0] depth;
    mid_drain_done = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // ---- directed cases ----
    send_noise(2);                         // before any start: dropped
    send_beat(8'h01, 1'b1);                // first signature byte wrong
    send_noise(2);                         // halted after error: dropped

    build_header(1'b0, 16'd1, 16'd1, DEPTH_RGB, 8'd0);
    file_bytes[IDX_TYPE] = 8'd3;           // unknown image type
    send_file();

    build_header(1'b1, 16'd1, 16'd1, DEPTH_RGB, 8'd0);
    file_bytes[SIG_LEN - 1] = 8'h80;       // last signature byte nonzero
    send_file();

    build_header(1'b0, 16'd0, 16'd1, DEPTH_RGB, 8'd0);    // zero width
    send_file();
    build_header(1'b1, 16'd1, 16'd0, DEPTH_RGBA, 8'd0);   // zero height
    send_file();
    build_header(1'b0, 16'd1, 16'd1, 8'd16, 8'd0);        // unsupported depth
    send_file();

    // raw 24-bit single pixel, then a byte after the image: dropped
    build_header(1'b0, 16'd1, 16'd1, DEPTH_RGB, 8'hFF);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h80);
    send_file();
    send_noise(1);

    // raw 32-bit, alpha at both extremes
    build_header(1'b0, 16'd2, 16'd1, DEPTH_RGBA, 8'd0);
    file_bytes.push_back(8'h00); file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00); file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'hFF); file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF); file_bytes.push_back(8'h00);
    send_file();

    // longest run: one packet covers all 128 pixels
    build_header(1'b1, 16'd128, 16'd1, DEPTH_RGBA, 8'd0);
    file_bytes.push_back(8'hFF);
    add_pixel(1'b1);
    send_file();

    // longest raw packet
    build_header(1'b1, 16'd128, 16'd1, DEPTH_RGB, 8'd0);
    file_bytes.push_back(8'h7F);
    repeat (128) add_pixel(1'b0);
    send_file();

    // packets asking for more pixels than the image holds
    build_header(1'b1, 16'd1, 16'd1, DEPTH_RGB, 8'd0);
    file_bytes.push_back(8'h81);
    send_file();
    build_header(1'b1, 16'd1, 16'd1, DEPTH_RGB, 8'd0);
    file_bytes.push_back(8'h01);
    send_file();

    // largest image; abandoned by the next start flag
    build_header(1'b1, 16'hFFFF, 16'hFFFF, DEPTH_RGBA, 8'd0);
    file_bytes.push_back(8'hFF);
    add_pixel(1'b1);
    file_bytes.push_back(8'h00);
    add_pixel(1'b1);
    send_file();

    build_header(1'b1, 16'd3, 16'd3, DEPTH_RGB, 8'd0);
    build_body(1'b1, 3, 3, 1'b0, 0);
    send_file();

    wait_drained();

    // ---- random files ----
    while (beats_sent < ITEM_TARGET) begin
      calm <= (beats_sent >= 600 && beats_sent < 850);
      if (!mid_drain_done && beats_sent >= 1000) begin
        wait_drained();
        mid_drain_done = 1'b1;
      end
      roll  = $urandom_range(99, 0);
      rle   = 1'($urandom_range(1, 0));
      four  = 1'($urandom_range(1, 0));
      w     = ($urandom_range(9, 0) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
      h     = (w > 6) ? $urandom_range(2, 1) : $urandom_range(6, 1);
      depth = four ? DEPTH_RGBA : DEPTH_RGB;
      build_header(rle, 16'(w), 16'(h), depth, 8'($urandom_range(255, 0)));
      if (roll < 70) begin
        // well-formed file, sometimes with trailing junk
        build_body(rle, w, h, four, 0);
        send_file();
        if ($urandom_range(4, 0) == 0) send_noise($urandom_range(3, 1));
      end else if (roll < 78) begin
        // run-length file likely to overflow
        build_body(1'b1, w, h, four, 30);
        file_bytes[IDX_TYPE] = TYPE_RLE;
        send_file();
      end else if (roll < 86) begin
        // cut short; the next start flag abandons it
        build_body(rle, w, h, four, 0);
        cut = $urandom_range(file_bytes.size() - 1, 1);
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        send_file();
      end else if (roll < 94) begin
        // broken header
        case ($urandom_range(3, 0))
          0: file_bytes[$urandom_range(SIG_LEN - 1, 0)] = 8'($urandom_range(255, 1));
          1: begin
            file_bytes[IDX_W_LO] = 8'd0;
            file_bytes[IDX_W_HI] = 8'd0;
          end
          2: begin
            file_bytes[IDX_H_LO] = 8'd0;
            file_bytes[IDX_H_HI] = 8'd0;
          end
          default: begin
            depth = 8'($urandom_range(255, 0));
            if (depth == DEPTH_RGB || depth == DEPTH_RGBA) depth = 8'd0;
            file_bytes[IDX_DEPTH] = depth;
          end
        endcase
        send_file();
      end else begin
        file_bytes.delete();
        send_noise($urandom_range(4, 1));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* tga_rle_pixel_decoder.f */
+incdir+src
src/tga_pkg.sv
src/tga_dec_core.sv
src/tga_rle_pixel_decoder.sv
tb/tga_rle_pixel_decoder_checker.sv
tb/tga_rle_pixel_decoder_tb.sv
